>>> hw/rtl/dsv_field_tokenizer_defines.svh
// assertion macros for the tokenizer top level
`ifndef DSV_FIELD_TOKENIZER_DEFINES_SVH
`define DSV_FIELD_TOKENIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked on every clock edge outside reset
`define DSVT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// property checked on every clock edge, reset included
`define DSVT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DSVT_ASSERT(lbl, clk, rstn, prop, msg)
`define DSVT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> hw/rtl/dsvt_pkg.sv
// types and constants of the field tokenizer
`default_nettype none

package dsvt_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] QuoteChar   = 8'h22;
  localparam logic [ByteW-1:0] NewlineChar = 8'h0A;
  localparam logic [ByteW-1:0] DelimReset  = 8'd44;

  // one result item
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_data;
    logic             field_end;
    logic             row_end;
  } res_t;

  // what the parser hands to the output register
  typedef struct packed {
    logic has_res;
    res_t res;
  } step_t;

endpackage

`default_nettype wire

>>> hw/rtl/dsvt_in_stage.sv
// input register of the field tokenizer
`default_nettype none

module dsvt_in_stage
  import dsvt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] in_byte_i,
  input  wire logic             end_of_stream_i,
  input  wire logic             pop_i,
  output logic                  item_valid_o,
  output logic [ByteW-1:0]      item_byte_o,
  output logic                  item_eos_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             eos_q;
  logic             accept;

  // room when empty or when the held item leaves this cycle
  assign in_ready_o = !valid_q || pop_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_byte_i;
      eos_q  <= end_of_stream_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_byte_o  = byte_q;
  assign item_eos_o   = eos_q;

endmodule

`default_nettype wire

>>> hw/rtl/dsvt_parse.sv
// per-byte tokenizer logic with quote state and delimiter register
`default_nettype none

module dsvt_parse
  import dsvt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  input  wire logic [ByteW-1:0] cfg_data_i,
  input  wire logic [ByteW-1:0] item_byte_i,
  input  wire logic             item_eos_i,
  input  wire logic             advance_i,
  output step_t                 step_o
);

  logic [ByteW-1:0] delim_q;
  logic             in_quotes_q, in_quotes_d;
  logic             quote_pending_q, quote_pending_d;
  logic             row_started_q, row_started_d;
  logic             is_quote;
  logic             quoted_eff;
  step_t            step;

  assign is_quote = (item_byte_i == QuoteChar);

  // a pending quote followed by another byte closed the quoted section
  assign quoted_eff = in_quotes_q && !(quote_pending_q && !is_quote);

  // decode one byte
  always_comb begin
    step            = '0;
    in_quotes_d     = quoted_eff;
    quote_pending_d = 1'b0;
    row_started_d   = 1'b1;
    if (item_eos_i) begin
      in_quotes_d               = 1'b0;
      row_started_d             = 1'b0;
      step.has_res              = row_started_q;
      step.res.field_end        = 1'b1;
      step.res.row_end          = 1'b1;
    end else if (quote_pending_q && is_quote) begin
      // doubled quote inside quotes
      step.has_res              = 1'b1;
      step.res.out_byte         = QuoteChar;
      step.res.is_data          = 1'b1;
    end else if (quoted_eff) begin
      if (is_quote) begin
        quote_pending_d         = 1'b1;
      end else begin
        step.has_res            = 1'b1;
        step.res.out_byte       = item_byte_i;
        step.res.is_data        = 1'b1;
      end
    end else if (is_quote) begin
      in_quotes_d               = 1'b1;
    end else if (item_byte_i == delim_q) begin
      step.has_res              = 1'b1;
      step.res.field_end        = 1'b1;
    end else if (item_byte_i == NewlineChar) begin
      row_started_d             = 1'b0;
      step.has_res              = 1'b1;
      step.res.field_end        = 1'b1;
      step.res.row_end          = 1'b1;
    end else begin
      step.has_res              = 1'b1;
      step.res.out_byte         = item_byte_i;
      step.res.is_data          = 1'b1;
    end
  end

  assign step_o = step;

  // tokenizer state, moves when the held item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quotes_q     <= 1'b0;
      quote_pending_q <= 1'b0;
      row_started_q   <= 1'b0;
    end else if (advance_i) begin
      in_quotes_q     <= in_quotes_d;
      quote_pending_q <= quote_pending_d;
      row_started_q   <= row_started_d;
    end
  end

  // delimiter register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q <= DelimReset;
    end else if (cfg_valid_i) begin
      delim_q <= cfg_data_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/dsvt_out_stage.sv
// result register of the field tokenizer
`default_nettype none

module dsvt_out_stage
  import dsvt_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  res_t      res_i,
  input  wire logic out_ready_i,
  output logic      can_load_o,
  output logic      out_valid_o,
  output res_t      res_o
);

  logic valid_q, valid_d;
  res_t res_q;

  // free when empty or when the held result transfers now
  assign can_load_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

>>> hw/rtl/dsv_field_tokenizer.sv
// Streaming tokenizer for delimiter-separated text with double-quote quoting.
// Input channel (in_valid_i/in_ready_o): one text byte per transfer, or an
// end-of-stream marker (end_of_stream_i high, byte ignored) that closes an
// unfinished row. Output channel (out_valid_o/out_ready_i): zero or one
// result per input byte, either a data byte (is_data_o) or a boundary
// (field_end_o, with row_end_o at a newline or end of stream).
// Config channel (cfg_valid_i/cfg_ready_o): writes the delimiter byte,
// always ready; write only while the block is idle.
// Path: a byte is held in the input register, decoded, and its result is
// loaded into the result register, from which it transfers on the output.
// Throughput: one byte per cycle unless the output stalls; the byte decode
// and the quote state update sit in one short stage between both registers.
// Reset: delimiter returns to a comma, quote and row state clear, both
// registers empty.
// Stall: while out_ready_i is low the result holds; a byte with a result then
// waits in the input register and in_ready_o drops until the result transfers.
// Bytes that give no result (quotes) pass without waiting on the output.
`default_nettype none
`include "dsv_field_tokenizer_defines.svh"

module dsv_field_tokenizer
  import dsvt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [ByteW-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] in_byte_i,
  input  wire logic             end_of_stream_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [ByteW-1:0]      out_byte_o,
  output logic                  is_data_o,
  output logic                  field_end_o,
  output logic                  row_end_o
);

  logic             item_valid;
  logic [ByteW-1:0] item_byte;
  logic             item_eos;
  logic             pop;
  logic             load;
  logic             can_load;
  step_t            step;
  res_t             res;

  assign cfg_ready_o = 1'b1;

  // held item leaves when it has no result or the result register is free
  assign pop  = item_valid && (!step.has_res || can_load);
  assign load = pop && step.has_res;

  dsvt_in_stage u_in (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_byte_i       (in_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .pop_i           (pop),
    .item_valid_o    (item_valid),
    .item_byte_o     (item_byte),
    .item_eos_o      (item_eos)
  );

  dsvt_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .item_byte_i (item_byte),
    .item_eos_i  (item_eos),
    .advance_i   (pop),
    .step_o      (step)
  );

  dsvt_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .res_i       (step.res),
    .out_ready_i (out_ready_i),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign out_byte_o  = res.out_byte;
  assign is_data_o   = res.is_data;
  assign field_end_o = res.field_end;
  assign row_end_o   = res.row_end;

  // checks on the result encoding and the stage handoff
  `DSVT_ASSERT(a_data_xor_bound, clk_i, rst_ni, out_valid_o |-> (is_data_o != field_end_o), "result is neither data nor boundary")
  `DSVT_ASSERT(a_row_has_field, clk_i, rst_ni, (out_valid_o && row_end_o) |-> field_end_o, "row end without field end")
  `DSVT_ASSERT(a_bound_zero, clk_i, rst_ni, (out_valid_o && !is_data_o) |-> (out_byte_o == '0), "boundary carries a byte")
  `DSVT_ASSERT(a_stall_full, clk_i, rst_ni, !in_ready_o |-> (item_valid && step.has_res && out_valid_o && !out_ready_i), "input stalled without a blocked result")
  `DSVT_ASSERT(a_load_lands, clk_i, rst_ni, load |=> out_valid_o, "loaded result not shown")

endmodule

`default_nettype wire
